[sv/dsm_pkg.sv]
`default_nettype none

package dsm_pkg;

  // Field widths
  localparam int LETTER_W    = 5;
  localparam int LEN_W       = 4;
  localparam int POS_W       = 32;
  localparam int PATTERN_W   = 60;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 60;

  // Config register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LETTERS = 2'd0,
    REG_PATTERN_LENGTH  = 2'd1
  } cfg_reg_t;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [LEN_W-1:0]    len_t;
  typedef logic [POS_W-1:0]    pos_t;

endpackage

`default_nettype wire

[sv/dsm_if.sv]
`default_nettype none

// Text item channel
interface dsm_text_if;
  logic                  valid;
  logic                  ready;
  dsm_pkg::letter_t      letter;
  logic                  first;
  modport source (output valid, letter, first, input ready);
  modport sink   (input valid, letter, first, output ready);
endinterface

// Result item channel
interface dsm_result_if;
  logic                  valid;
  logic                  ready;
  logic                  match;
  dsm_pkg::pos_t         shift;
  dsm_pkg::len_t         matched_length;
  modport source (output valid, match, shift, matched_length, input ready);
  modport sink   (input valid, match, shift, matched_length, output ready);
endinterface

// Config write channel
interface dsm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dsm_pkg::CFG_INDEX_W-1:0]     index;
  logic [dsm_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/dsm_cfg.sv]
`default_nettype none

// Pattern registers plus the prefix/suffix (border) table derived from them.
// border[q][l]: the first l pattern letters are a suffix of the first q.
module dsm_cfg #(
  parameter int MAX_PATTERN = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  dsm_cfg_if.sink                cfg,
  output dsm_pkg::letter_t       pat [MAX_PATTERN],
  output dsm_pkg::len_t          eff_len,
  output logic [MAX_PATTERN-1:0] border [MAX_PATTERN+1]
);

  logic [dsm_pkg::PATTERN_W-1:0] pattern_letters;
  dsm_pkg::len_t                 pattern_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_letters <= '0;
      pattern_length  <= dsm_pkg::LEN_W'(1);
    end else if (cfg.valid) begin
      unique case (dsm_pkg::cfg_reg_t'(cfg.index))
        dsm_pkg::REG_PATTERN_LETTERS: begin
          pattern_letters <= cfg.data[dsm_pkg::PATTERN_W-1:0];
        end
        dsm_pkg::REG_PATTERN_LENGTH: begin
          pattern_length <= cfg.data[dsm_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pat[i] = pattern_letters[dsm_pkg::LETTER_W*i +: dsm_pkg::LETTER_W];
    end
  end

  // Zero length acts as one, anything past the lane count is clipped.
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = dsm_pkg::LEN_W'(1);
    end else if (pattern_length > dsm_pkg::LEN_W'(MAX_PATTERN)) begin
      eff_len = dsm_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = pattern_length;
    end
  end

  always_comb begin
    for (int q = 0; q <= MAX_PATTERN; q++) begin
      for (int l = 0; l < MAX_PATTERN; l++) begin
        border[q][l] = (l <= q);
        for (int j = 0; j < MAX_PATTERN - 1; j++) begin
          if (l <= q && j < l) begin
            if (pat[j] != pat[q - l + j]) begin
              border[q][l] = 1'b0;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/dsm_step.sv]
`default_nettype none

// One automaton transition: pick the longest candidate prefix.
module dsm_step #(
  parameter int MAX_PATTERN   = 12,
  parameter int ALPHABET_SIZE = 26
) (
  input  wire dsm_pkg::letter_t       pat [MAX_PATTERN],
  input  wire dsm_pkg::len_t          eff_len,
  input  wire logic [MAX_PATTERN-1:0] border [MAX_PATTERN+1],
  input  wire dsm_pkg::len_t          state,
  input  wire dsm_pkg::letter_t       letter,
  output dsm_pkg::len_t               state_next
);

  dsm_pkg::len_t          q;
  logic [MAX_PATTERN-1:0] row;
  logic [MAX_PATTERN-1:0] cand;

  assign q   = (state > eff_len) ? eff_len : state;
  assign row = border[q];

  // Candidate k (lane k-1): letter extends a border of the current prefix.
  always_comb begin
    for (int k = 1; k <= MAX_PATTERN; k++) begin
      cand[k-1] = (k <= int'(q) + 1) && (k <= int'(eff_len)) &&
                  (pat[k-1] == letter) && row[k-1];
    end
  end

  always_comb begin
    state_next = '0;
    if (int'(letter) < ALPHABET_SIZE) begin
      for (int k = 1; k <= MAX_PATTERN; k++) begin
        if (cand[k-1]) begin
          state_next = dsm_pkg::LEN_W'(k);
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/dfa_string_matcher.sv]
`default_nettype none

// Finite-automaton string matcher. Text letters (0 = a .. 25 = z) arrive one
// item per cycle on the text channel unless the result side stalls; each
// one yields exactly one result item carrying the automaton state after that
// letter (matched_length), a match flag when the whole pattern ends on that
// letter, and on a match the start position (shift, modulo 2^32; zero
// otherwise). Setting first on an item starts a new text: that letter is
// position 0 and the match is restarted. The pattern (five bits per letter,
// letter zero lowest) and its length are written over the cfg channel,
// register 0 and 1, while no items are in flight; a length of 0 acts as 1
// and lengths above MAX_PATTERN are clipped. Throughput is one item per cycle
// while the result side keeps up. Accepted text goes into the input register;
// the next-state select is combinational and feeds the result register and
// the state, which load together once the result register is free. The border
// table that the select uses is pure logic off the pattern registers, so an
// item may follow a config write in the very next cycle.
module dfa_string_matcher #(
  parameter int MAX_PATTERN   = 12,
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic   clk,
  input  wire logic   rst,
  dsm_cfg_if.sink     cfg,
  dsm_text_if.sink    text,
  dsm_result_if.source result
);

  // Config and derived tables
  dsm_pkg::letter_t       pat [MAX_PATTERN];
  dsm_pkg::len_t          eff_len;
  logic [MAX_PATTERN-1:0] border [MAX_PATTERN+1];

  dsm_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pat     (pat),
    .eff_len (eff_len),
    .border  (border)
  );

  // Input register
  logic             in_valid;
  dsm_pkg::letter_t in_letter;
  logic             in_first;

  // Automaton state
  dsm_pkg::len_t prefix_state;
  dsm_pkg::pos_t text_position;

  // Result register
  logic          out_valid;
  logic          out_match;
  dsm_pkg::pos_t out_shift;
  dsm_pkg::len_t out_length;

  // advance: the held item moves into the result register this cycle
  logic          advance;
  dsm_pkg::len_t cur_state;
  dsm_pkg::pos_t cur_pos;
  dsm_pkg::len_t state_next;
  logic          hit;

  assign advance    = in_valid && (!out_valid || result.ready);
  assign text.ready = !in_valid || advance;

  // A new text restarts both the match and the position count.
  assign cur_state = in_first ? '0 : prefix_state;
  assign cur_pos   = in_first ? '0 : text_position;

  dsm_step #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_step (
    .pat        (pat),
    .eff_len    (eff_len),
    .border     (border),
    .state      (cur_state),
    .letter     (in_letter),
    .state_next (state_next)
  );

  assign hit = (state_next == eff_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      in_letter <= text.letter;
      in_first  <= text.first;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_state  <= '0;
      text_position <= '0;
    end else if (advance) begin
      prefix_state  <= state_next;
      text_position <= cur_pos + dsm_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Shift is position - length + 1, wrapping at 32 bits.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_match  <= hit;
      out_shift  <= hit ? (cur_pos + dsm_pkg::POS_W'(1) - dsm_pkg::POS_W'(eff_len)) : '0;
      out_length <= state_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.match          = out_match;
  assign result.shift          = out_shift;
  assign result.matched_length = out_length;

`ifndef SYNTHESIS
  // A match always reports the full pattern length as the state.
  a_match_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_match |-> out_length == eff_len)
    else $error("match reported with partial state");

  // No match, no shift.
  a_shift_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_match |-> out_shift == '0)
    else $error("nonzero shift without match");

  // The state never runs past the lane count.
  a_state_bound: assert property (@(posedge clk) disable iff (rst)
    prefix_state <= dsm_pkg::LEN_W'(MAX_PATTERN))
    else $error("prefix state out of range");

  // Every processed item moves the position by one from its own start.
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> text_position == $past(cur_pos) + dsm_pkg::POS_W'(1))
    else $error("text position did not advance");

  // A held item is not dropped while the result side stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_letter))
    else $error("stalled item lost");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
`default_nettype none

// Checks the string matcher against a shadow automaton kept by this bench.
// Every text item gives exactly one result item. The expected result is
// computed when the text item is accepted and is checked against the result
// items in order.
module tb;

  localparam int MAX_PATTERN   = 12;
  localparam int ALPHABET_SIZE = 26;
  localparam int LONG_HOLD     = 64;    // receiver back-pressure stretch
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int DRAIN_CYCLES  = 4;     // extra settle time after the queues drain

  // Register indexes the block does not map; writes there must be ignored.
  localparam logic [dsm_pkg::CFG_INDEX_W-1:0] UNMAPPED_REG_LO = 2'd2;
  localparam logic [dsm_pkg::CFG_INDEX_W-1:0] UNMAPPED_REG_HI = 2'd3;

  typedef struct {
    dsm_pkg::letter_t letter;
    logic             first;
  } text_item_t;

  typedef struct {
    logic           match;
    dsm_pkg::pos_t  shift;
    dsm_pkg::len_t  matched_length;
  } match_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dsm_cfg_if    cfg_bus ();
  dsm_text_if   text_bus ();
  dsm_result_if result_bus ();

  dfa_string_matcher dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .text   (text_bus),
    .result (result_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow copy of the registers and of the automaton state.
  logic [dsm_pkg::PATTERN_W-1:0] pattern_cfg = '0;
  dsm_pkg::len_t                 length_cfg  = dsm_pkg::len_t'(1);
  dsm_pkg::len_t                 prefix_q    = '0;
  dsm_pkg::pos_t                 position_q  = '0;

  text_item_t  pending_text[$];   // items waiting for the driver
  match_item_t due_results[$];    // predicted results, oldest first

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int hold_token   = 0;   // bumped by the sequencer to ask for a long hold
  int mismatches   = 0;

  // ---------------------------------------------------------------------
  // Automaton
  // ---------------------------------------------------------------------

  function automatic int pattern_letter(int idx);
    if (idx >= MAX_PATTERN) return 0;
    return int'(pattern_cfg[5*idx +: 5]);
  endfunction

  // Zero acts as one, anything past the maximum is clipped.
  function automatic int active_length();
    int m;
    m = int'(length_cfg);
    if (m < 1) m = 1;
    if (m > MAX_PATTERN) m = MAX_PATTERN;
    return m;
  endfunction

  // Longest pattern prefix that is a suffix of (matched prefix + letter).
  function automatic int advance_prefix(int q, int a, int m);
    int  k;
    bit  ok;
    if (a >= ALPHABET_SIZE) return 0;
    for (k = (q + 1 < m) ? q + 1 : m; k > 0; k--) begin
      ok = (pattern_letter(k - 1) == a);
      for (int j = 0; ok && j + 1 < k; j++) begin
        if (pattern_letter(j) != pattern_letter(q + 1 - k + j)) ok = 1'b0;
      end
      if (ok) return k;
    end
    return 0;
  endfunction

  function automatic void predict_letter(dsm_pkg::letter_t letter, logic first);
    int          m;
    int          q;
    int          nq;
    match_item_t r;
    m = active_length();
    if (first) begin
      prefix_q   = '0;
      position_q = '0;
    end
    // A lowered length register leaves the state above it: clip first.
    q  = (int'(prefix_q) > m) ? m : int'(prefix_q);
    nq = advance_prefix(q, int'(letter), m);
    r.matched_length = dsm_pkg::len_t'(nq);
    r.match          = (nq == m);
    r.shift          = r.match ?
                       position_q - dsm_pkg::pos_t'(m) + dsm_pkg::pos_t'(1) : '0;
    prefix_q   = dsm_pkg::len_t'(nq);
    position_q = position_q + dsm_pkg::pos_t'(1);
    due_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Text driver: one item per handshake, random gaps per send_gap_pct
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    text_item_t nxt;
    if (rst) begin
      text_bus.valid <= 1'b0;
    end else begin
      if (text_bus.valid && text_bus.ready) predict_letter(text_bus.letter, text_bus.first);
      if (!text_bus.valid || text_bus.ready) begin
        if (pending_text.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = pending_text.pop_front();
          text_bus.valid  <= 1'b1;
          text_bus.letter <= nxt.letter;
          text_bus.first  <= nxt.first;
        end else begin
          text_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor and receiver back-pressure
  // ---------------------------------------------------------------------

  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    match_item_t exp;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (due_results.size() == 0) begin
          $error("result item with no text item pending: match %0d shift %0d length %0d",
                 result_bus.match, result_bus.shift, result_bus.matched_length);
          mismatches++;
        end else begin
          exp = due_results.pop_front();
          if (result_bus.match !== exp.match) begin
            $error("match: expected %0d, got %0d", exp.match, result_bus.match);
            mismatches++;
          end
          if (result_bus.shift !== exp.shift) begin
            $error("shift: expected %0d, got %0d", exp.shift, result_bus.shift);
            mismatches++;
          end
          if (result_bus.matched_length !== exp.matched_length) begin
            $error("matched_length: expected %0d, got %0d",
                   exp.matched_length, result_bus.matched_length);
            mismatches++;
          end
        end
      end
      // A long hold lets the pipe fill so that text ready has to drop.
      if (hold_token != hold_seen) begin
        hold_seen        <= hold_token;
        hold_left        <= LONG_HOLD;
        result_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left        <= hold_left - 1;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: any handshake resets it
  // ---------------------------------------------------------------------

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (text_bus.valid && text_bus.ready) || (result_bus.valid && result_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $error("no handshake for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------

  // Register write; the shadow copy follows at the handshake.
  task automatic write_reg(logic [dsm_pkg::CFG_INDEX_W-1:0] idx,
                           logic [dsm_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == dsm_pkg::REG_PATTERN_LETTERS) pattern_cfg = value[dsm_pkg::PATTERN_W-1:0];
    else if (idx == dsm_pkg::REG_PATTERN_LENGTH) length_cfg = value[dsm_pkg::LEN_W-1:0];
  endtask

  // Wait until every text item is in and every result is out, then let the
  // pipe settle. Ends on a falling edge so queue and knob updates stay clear
  // of the clocked processes.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_text.size() != 0 || text_bus.valid || due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic void queue_item(int letter, bit first);
    text_item_t it;
    it.letter = dsm_pkg::letter_t'(letter);
    it.first  = first;
    pending_text.push_back(it);
  endfunction

  // One text built from chunks: whole pattern copies, pattern prefixes, runs
  // over the pattern's alphabet, and short runs from the full 5-bit range.
  function automatic int queue_text(bit fresh, int alph);
    int m;
    int kind;
    int n;
    int count = 0;
    bit f;
    f = fresh;
    m = active_length();
    repeat ($urandom_range(1, 5)) begin
      kind = $urandom_range(9);
      if (kind < 4) begin
        for (int i = 0; i < m; i++) begin
          queue_item(pattern_letter(i), f);
          f = 1'b0;
          count++;
        end
      end else if (kind < 7) begin
        n = $urandom_range(1, m);
        for (int i = 0; i < n; i++) begin
          queue_item(pattern_letter(i), f);
          f = 1'b0;
          count++;
        end
      end else begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          queue_item((kind < 9) ? $urandom_range(alph - 1) : $urandom_range(31), f);
          f = 1'b0;
          count++;
        end
      end
    end
    return count;
  endfunction

  function automatic logic [dsm_pkg::PATTERN_W-1:0] random_pattern(int alph);
    logic [dsm_pkg::PATTERN_W-1:0] p;
    for (int i = 0; i < MAX_PATTERN; i++) p[5*i +: 5] = 5'($urandom_range(alph - 1));
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------

  // Per random phase: pattern length (-1 draws one), pattern alphabet size.
  int len_plan  [8] = '{12, 15, 1, 0, 13, 2, -1, -1};
  int alph_plan [8] = '{2, 32, 3, 32, 4, 26, 2, 3};
  int gap_plan  [4] = '{0, 67, 0, 33};
  int stall_plan[4] = '{0, 0, 67, 33};

  initial begin
    int queued;
    text_bus.valid   = 1'b0;
    text_bus.letter  = '0;
    text_bus.first   = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = '0;
    cfg_bus.data     = '0;
    result_bus.ready = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset registers: pattern is a single 'a'. Covers the first
    // flag mid-stream and letters past the alphabet, at the edge and at 31.
    queue_item(0, 1'b1);
    queue_item(0, 1'b0);
    queue_item(25, 1'b0);
    queue_item(31, 1'b0);
    queue_item(26, 1'b0);
    queue_item(5, 1'b1);
    queue_item(0, 1'b0);
    wait_idle();

    // Full-length pattern "ababacababaz", scanned once from a fresh text.
    write_reg(dsm_pkg::REG_PATTERN_LETTERS, {5'd25, 5'd0, 5'd1, 5'd0, 5'd1, 5'd0,
                                             5'd2, 5'd0, 5'd1, 5'd0, 5'd1, 5'd0});
    write_reg(dsm_pkg::REG_PATTERN_LENGTH, 60'd12);
    @(negedge clk);
    for (int i = 0; i < MAX_PATTERN; i++) queue_item(pattern_letter(i), i == 0);
    wait_idle();

    // Shrink the length under the current state and keep the text going.
    write_reg(dsm_pkg::REG_PATTERN_LENGTH, 60'd3);
    @(negedge clk);
    queue_item(0, 1'b0);
    queue_item(1, 1'b0);
    queue_item(0, 1'b0);
    wait_idle();

    // Unmapped index is a no-op; a length of zero behaves as one.
    write_reg(UNMAPPED_REG_LO, '1);
    write_reg(dsm_pkg::REG_PATTERN_LENGTH, {56'hFFFFFFFFFFFFFF, 4'd0});
    @(negedge clk);
    queue_item(0, 1'b0);
    queue_item(1, 1'b0);
    wait_idle();

    // Random phases, each with its own registers and idling mix.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(dsm_pkg::REG_PATTERN_LETTERS,
                (ph == 3) ? '1 : random_pattern(alph_plan[ph]));
      write_reg(dsm_pkg::REG_PATTERN_LENGTH,
                (len_plan[ph] < 0) ? 60'($urandom_range(1, MAX_PATTERN)) : 60'(len_plan[ph]));
      if (ph == 4) write_reg(UNMAPPED_REG_HI, 60'd5);
      @(negedge clk);
      send_gap_pct = gap_plan[ph % 4];
      stall_pct    = stall_plan[ph % 4];
      // Back-pressure burst while the sender streams without gaps.
      if (ph % 4 == 0) hold_token++;
      queued = 0;
      // Phases 2 and 6 pick up the previous text across the register write.
      while (queued < 86) begin
        queued += queue_text((queued != 0) || (ph != 2 && ph != 6), alph_plan[ph]);
      end
      wait_idle();
    end

    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d result items never arrived", due_results.size());
    end
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[dfa_string_matcher.f]
sv/dsm_pkg.sv
sv/dsm_if.sv
sv/dsm_cfg.sv
sv/dsm_step.sv
sv/dfa_string_matcher.sv
dv/tb.sv
